[src/nmd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmd_pkg
// Shared widths, register codes and pipeline record types of the normal map
// diffuse shader.
// ----------------------------------------------------------------------------
package nmd_pkg;

	localparam int LIGHT_FRAC_BITS = 14;
	localparam int LIGHT_W = 16;
	localparam int N_W     = 10;              // decoded normal, -255..255
	localparam int MUL_W   = N_W + LIGHT_W;   // one dot-product term
	localparam int D_W     = MUL_W + 2;       // sum of three terms
	localparam int DMAG_W  = 25;              // |d| <= 3*255*32768 < 2**25
	localparam int DD_W    = 2 * DMAG_W;
	localparam int SQ_W    = 16;
	localparam int S_W     = 18;
	localparam int Q_W     = 18;              // intensity bits searched
	localparam int QS_W    = Q_W + S_W;
	localparam int CAND_W  = 58;
	localparam int BIT_W   = 5;
	localparam int SCL_W   = 8 + Q_W;
	localparam int ADDR_W  = 4;

	typedef enum logic [1:0] {
		REG_LIGHT_X = 2'd0,
		REG_LIGHT_Y = 2'd1,
		REG_LIGHT_Z = 2'd2
	} nmd_reg_t;

	typedef struct packed {
		logic [7:0] normal_red;
		logic [7:0] normal_green;
		logic [7:0] normal_blue;
		logic [7:0] base_red;
		logic [7:0] base_green;
		logic [7:0] base_blue;
	} nmd_pix_t;

	typedef struct packed {
		logic              valid;
		logic [DD_W-1:0]   dd;
		logic [S_W-1:0]    s;
		logic [Q_W-1:0]    q;
		logic [DD_W-1:0]   p;    // q*q*s
		logic [QS_W-1:0]   qs;   // q*s
		logic [7:0]        base_red;
		logic [7:0]        base_green;
		logic [7:0]        base_blue;
	} nmd_cell_t;

endpackage

[src/nmd_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmd_pixel_if / nmd_shade_if
// Valid/ready channels for input pixels and shaded results.
// ----------------------------------------------------------------------------
interface nmd_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] normal_red;
	logic [7:0] normal_green;
	logic [7:0] normal_blue;
	logic [7:0] base_red;
	logic [7:0] base_green;
	logic [7:0] base_blue;

	modport source (output valid, normal_red, normal_green, normal_blue,
		base_red, base_green, base_blue, input ready);
	modport sink (input valid, normal_red, normal_green, normal_blue,
		base_red, base_green, base_blue, output ready);
endinterface

interface nmd_shade_if;
	logic       valid;
	logic       ready;
	logic [7:0] shaded_red;
	logic [7:0] shaded_green;
	logic [7:0] shaded_blue;

	modport source (output valid, shaded_red, shaded_green, shaded_blue, input ready);
	modport sink (input valid, shaded_red, shaded_green, shaded_blue, output ready);
endinterface

[src/nmd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmd_front
// Decode the normal, form the dot product, the squared length and the
// squared dot product over four stages.
// ----------------------------------------------------------------------------
module nmd_front
	import nmd_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  nmd_pix_t                  in_pix,
	input  logic signed [LIGHT_W-1:0] light_x,
	input  logic signed [LIGHT_W-1:0] light_y,
	input  logic signed [LIGHT_W-1:0] light_z,
	output nmd_cell_t                 out_cell
);

	logic                    vld_s1, vld_s2, vld_s3, vld_s4;
	logic signed [N_W-1:0]   nx_s1, ny_s1, nz_s1;
	logic [23:0]             base_s1, base_s2, base_s3, base_s4;
	logic signed [MUL_W-1:0] mx_s2, my_s2, mz_s2;
	logic [SQ_W-1:0]         qx_s2, qy_s2, qz_s2;
	logic signed [D_W-1:0]   d_s3;
	logic [S_W-1:0]          s_s3, s_s4;
	logic [DD_W-1:0]         dd_s4;

	function automatic logic signed [N_W-1:0] decode(input logic [7:0] c);
		return $signed({1'b0, c, 1'b0}) - N_W'(255);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s1   <= decode(in_pix.normal_red);
			ny_s1   <= decode(in_pix.normal_green);
			nz_s1   <= decode(in_pix.normal_blue);
			base_s1 <= {in_pix.base_red, in_pix.base_green, in_pix.base_blue};

			mx_s2   <= MUL_W'(nx_s1 * light_x);
			my_s2   <= MUL_W'(ny_s1 * light_y);
			mz_s2   <= MUL_W'(nz_s1 * light_z);
			qx_s2   <= SQ_W'(nx_s1 * nx_s1);
			qy_s2   <= SQ_W'(ny_s1 * ny_s1);
			qz_s2   <= SQ_W'(nz_s1 * nz_s1);
			base_s2 <= base_s1;

			d_s3    <= D_W'(mx_s2) + D_W'(my_s2) + D_W'(mz_s2);
			s_s3    <= S_W'(qx_s2) + S_W'(qy_s2) + S_W'(qz_s2);
			base_s3 <= base_s2;

			// facing away: zero target keeps every search bit clear
			dd_s4   <= (d_s3 > 0) ? d_s3[DMAG_W-1:0] * d_s3[DMAG_W-1:0] : '0;
			s_s4    <= s_s3;
			base_s4 <= base_s3;
		end
	end

	always_comb begin
		out_cell            = '0;
		out_cell.valid      = vld_s4;
		out_cell.dd         = dd_s4;
		out_cell.s          = s_s4;
		out_cell.base_red   = base_s4[23:16];
		out_cell.base_green = base_s4[15:8];
		out_cell.base_blue  = base_s4[7:0];
	end

endmodule

[src/nmd_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmd_cell
// One bit of the intensity search: try the bit, keep it when
// (q + 2^b)^2 * s still fits under d^2, and update q*s and q*q*s by shifts.
// ----------------------------------------------------------------------------
module nmd_cell
	import nmd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [BIT_W-1:0] bit_idx,
	input  nmd_cell_t        in_cell,
	output nmd_cell_t        out_cell
);

	logic [CAND_W-1:0] cand;
	logic              take;
	logic              vld_q;
	nmd_cell_t         nxt;
	nmd_cell_t         cell_q;

	assign cand = CAND_W'(in_cell.p)
		+ (CAND_W'(in_cell.qs) << (bit_idx + BIT_W'(1)))
		+ (CAND_W'(in_cell.s) << {bit_idx, 1'b0});
	assign take = cand <= CAND_W'(in_cell.dd);

	always_comb begin
		nxt = in_cell;
		if (take) begin
			nxt.q  = in_cell.q | (Q_W'(1) << bit_idx);
			nxt.p  = DD_W'(cand);
			nxt.qs = in_cell.qs + (QS_W'(in_cell.s) << bit_idx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= in_cell.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cell_q <= nxt;
		end
	end

	always_comb begin
		out_cell       = cell_q;
		out_cell.valid = vld_q;
	end

endmodule

[src/nmd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmd_back
// Scale the base colour by the intensity, truncate and saturate.
// ----------------------------------------------------------------------------
module nmd_back
	import nmd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  nmd_cell_t   in_cell,
	output logic        out_valid,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue
);

	logic             vld_s1, vld_q;
	logic [SCL_W-1:0] pr_s1, pg_s1, pb_s1;
	logic [7:0]       r_q, g_q, b_q;

	function automatic logic [7:0] sat(input logic [SCL_W-1:0] p);
		logic [SCL_W-LIGHT_FRAC_BITS-1:0] v;
		v = p[SCL_W-1:LIGHT_FRAC_BITS];
		return (v > 255) ? 8'hFF : v[7:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_q  <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_cell.valid;
			vld_q  <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pr_s1 <= SCL_W'(in_cell.base_red) * SCL_W'(in_cell.q);
			pg_s1 <= SCL_W'(in_cell.base_green) * SCL_W'(in_cell.q);
			pb_s1 <= SCL_W'(in_cell.base_blue) * SCL_W'(in_cell.q);
			r_q   <= sat(pr_s1);
			g_q   <= sat(pg_s1);
			b_q   <= sat(pb_s1);
		end
	end

	assign out_valid = vld_q;
	assign out_red   = r_q;
	assign out_green = g_q;
	assign out_blue  = b_q;

endmodule

[src/normal_map_diffuse_shader.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// normal_map_diffuse_shader
// Per-pixel Lambert shading from a normal-map sample and a base colour.
// ----------------------------------------------------------------------------
//  channel    dir  handshake        payload
//  pixel_in   in   valid/ready      normal_red/green/blue, base_red/green/blue
//  shade_out  out  valid/ready      shaded_red/green/blue
//  apb        in   psel/penable     light_x @0x0, light_y @0x4, light_z @0x8
//
//  One pixel per cycle unless the output stalls; 4 front stages, a chain
//  of 18 search cells (one intensity bit each, MSB first), 2 scaling stages.
//  The cell chain sets the latency; each cell is one wide add and compare.
//  Reset clears all valid bits and loads the light to (0, 0, 1.0).
//  The whole pipeline advances together; a stalled output holds every stage.
// ----------------------------------------------------------------------------
module normal_map_diffuse_shader
	import nmd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	nmd_pixel_if.sink         pixel_in,
	nmd_shade_if.source       shade_out,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic signed [LIGHT_W-1:0] light_x_q, light_y_q, light_z_q;
	logic                      advance;
	logic                      cfg_wr;
	nmd_reg_t                  reg_sel;
	nmd_pix_t                  pix;
	nmd_cell_t                 chain [Q_W+1];

	// Register file: write on the access phase, decode word index only.
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign reg_sel = nmd_reg_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_x_q <= '0;
			light_y_q <= '0;
			light_z_q <= LIGHT_W'(1 << LIGHT_FRAC_BITS);
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_LIGHT_X: light_x_q <= pwdata[LIGHT_W-1:0];
				REG_LIGHT_Y: light_y_q <= pwdata[LIGHT_W-1:0];
				REG_LIGHT_Z: light_z_q <= pwdata[LIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_LIGHT_X: prdata = 32'(light_x_q);
			REG_LIGHT_Y: prdata = 32'(light_y_q);
			REG_LIGHT_Z: prdata = 32'(light_z_q);
			default:     prdata = '0;
		endcase
	end

	// Advance everything when the output slot is free or being drained.
	assign advance        = !shade_out.valid || shade_out.ready;
	assign pixel_in.ready = advance;

	always_comb begin
		pix.normal_red   = pixel_in.normal_red;
		pix.normal_green = pixel_in.normal_green;
		pix.normal_blue  = pixel_in.normal_blue;
		pix.base_red     = pixel_in.base_red;
		pix.base_green   = pixel_in.base_green;
		pix.base_blue    = pixel_in.base_blue;
	end

	nmd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (advance),
		.in_valid (pixel_in.valid),
		.in_pix   (pix),
		.light_x  (light_x_q),
		.light_y  (light_y_q),
		.light_z  (light_z_q),
		.out_cell (chain[0])
	);

	// Cell i decides intensity bit Q_W-1-i.
	for (genvar i = 0; i < Q_W; i++) begin : g_cell
		nmd_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (advance),
			.bit_idx  (BIT_W'(Q_W - 1 - i)),
			.in_cell  (chain[i]),
			.out_cell (chain[i+1])
		);
	end

	nmd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.in_cell   (chain[Q_W]),
		.out_valid (shade_out.valid),
		.out_red   (shade_out.shaded_red),
		.out_green (shade_out.shaded_green),
		.out_blue  (shade_out.shaded_blue)
	);

	// A completed write to light_z lands in the register.
	a_cfg_z: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr && paddr[3:2] == REG_LIGHT_Z |=> light_z_q == $past(pwdata[LIGHT_W-1:0]))
		else $error("light_z write lost");

	// The search never overshoots its target.
	a_search: assert property (@(posedge clk) disable iff (!arst_n)
		chain[Q_W].valid |-> chain[Q_W].p <= chain[Q_W].dd)
		else $error("search overshoot");

	// A stall freezes the search output.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(chain[Q_W].q) && $stable(chain[Q_W].valid))
		else $error("chain moved during stall");

endmodule
